>>> design/assert_macros.svh
// Assertion helpers shared by the ring buffer modules.
// Checks are compiled for simulation only and vanish in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define BRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BRB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `BRB_ASSERT(lbl, clk, rst_n, !(expr), msg)

`else

`define BRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> design/brb_pkg.sv
`default_nettype none

package brb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DATA_W      = 8;
  localparam int ACT_W       = 4;
  localparam int OFS_W       = 10;
  localparam int CNT_W       = 11;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(STORE_DEPTH);

  // Register index taken from the word address of the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH      = 4'd0,
    ACT_POP       = 4'd1,
    ACT_PEEK      = 4'd2,
    ACT_STAGE     = 4'd3,
    ACT_OVERWRITE = 4'd4,
    ACT_ADV_RD    = 4'd5,
    ACT_REW_RD    = 4'd6,
    ACT_COMMIT_WR = 4'd7,
    ACT_RETRACT_WR = 4'd8
  } brb_action_e;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } brb_mem_req_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] value;
  } brb_cfg_t;

  typedef struct packed {
    logic             accepted;
    logic             rd_en;
    logic [CNT_W-1:0] readable;
    logic [CNT_W-1:0] writable;
  } brb_res_t;

endpackage

`default_nettype wire

>>> design/byte_ring_buffer_with_peek.sv
// Byte ring buffer with peek, staged writes and pointer moves.
// Input channel (in_valid_i / in_stall_o) carries one byte action per item:
// push, pop, peek, stage write, overwrite, or a read or write pointer move.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item: the byte read (pop or peek), an accepted flag, and the held and free
// byte counts after the action, plus the echoed end-of-transfer mark.
// A result passes through the pending stage and then the output register before
// it is valid. Throughput is one item per cycle while the output is taken; the
// pending stage holds each item for the byte store's registered read data.
// The APB port holds the capacity register at address 0; a write takes effect
// only while the buffer holds no bytes and also returns both pointers to 0.
// After reset every entry of the store is swept to zero, during which
// in_stall_o stays high; configuration writes are taken meanwhile.
// When the receiver stalls, the finished result waits in the output register
// and one further item may complete into the pending stage before the input
// channel stalls.
`default_nettype none

`include "assert_macros.svh"

module byte_ring_buffer_with_peek
  import brb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ACT_W-1:0]   action_i,
  input  wire logic [DATA_W-1:0]  data_byte_i,
  input  wire logic [OFS_W-1:0]   offset_i,
  input  wire logic [CNT_W-1:0]   step_i,
  input  wire logic               last_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [DATA_W-1:0]       read_data_o,
  output logic                    accepted_o,
  output logic [CNT_W-1:0]        readable_count_o,
  output logic [CNT_W-1:0]        writable_count_o,
  output logic                    end_of_transfer_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } brb_state_e;

  brb_state_e        state_q, state_d;
  brb_mem_req_t      mem_req;
  brb_res_t          res;
  brb_res_t          pend_q;
  logic              pend_eot_q;
  brb_cfg_t          cfg;
  logic [CNT_W-1:0]  cap;
  logic [DATA_W-1:0] mem_rdata;
  logic              clearing;
  logic              accept;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  logic              out_acc_q;
  logic [CNT_W-1:0]  out_rd_cnt_q;
  logic [CNT_W-1:0]  out_wr_cnt_q;
  logic              out_eot_q;

  assign pready   = 1'b1;
  assign cfg.we   = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_CAPACITY);
  assign cfg.value = pwdata[CNT_W-1:0];
  assign prdata   = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(cap) : '0;

  assign out_load   = (state_q == ST_RESP) & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = clearing | ((state_q == ST_RESP) & ~out_load);
  assign accept     = in_valid_i & ~in_stall_o;

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .offset_i    (offset_i),
    .step_i      (step_i),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .res_o       (res),
    .cap_o       (cap)
  );

  brb_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (clearing)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load && !accept) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result waits in the pending stage here for the store's registered read data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q     <= res;
      pend_eot_q <= last_byte_i;
    end
    if (out_load) begin
      out_data_q   <= pend_q.rd_en ? mem_rdata : '0;
      out_acc_q    <= pend_q.accepted;
      out_rd_cnt_q <= pend_q.readable;
      out_wr_cnt_q <= pend_q.writable;
      out_eot_q    <= pend_eot_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_data_q;
  assign accepted_o        = out_acc_q;
  assign readable_count_o  = out_rd_cnt_q;
  assign writable_count_o  = out_wr_cnt_q;
  assign end_of_transfer_o = out_eot_q;

  `BRB_ASSERT(a_refused_reads_zero, clk_i, rst_ni, (out_valid_q && !out_acc_q) |-> (out_data_q == '0), "refused item returned data")
  `BRB_ASSERT(a_counts_sum_to_cap, clk_i, rst_ni, out_load |=> (out_rd_cnt_q + out_wr_cnt_q == $past(cap)), "held plus free differs from capacity")
  `BRB_ASSERT_NEVER(a_no_accept_while_clearing, clk_i, rst_ni, accept && clearing, "item taken during clear sweep")

endmodule

`default_nettype wire

>>> design/brb_store.sv
`default_nettype none

`include "assert_macros.svh"

module brb_store
  import brb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire brb_mem_req_t      req_i,
  output logic [DATA_W-1:0]      rdata_o,
  output logic                   busy_o
);

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // After reset a sweep writes zero to every entry, one per cycle.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = req_i.en & req_i.we;
      wr_addr = req_i.addr;
      wr_data = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

  `BRB_ASSERT_NEVER(a_no_req_while_clearing, clk_i, rst_ni, clr_busy_q && req_i.en, "access during clear sweep")
  `BRB_ASSERT(a_clear_ends_at_top, clk_i, rst_ni, (clr_busy_q && !clr_busy_d) |-> (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)), "clear sweep ended early")

endmodule

`default_nettype wire

>>> design/brb_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module brb_ctrl
  import brb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [DATA_W-1:0] data_byte_i,
  input  wire logic [OFS_W-1:0]  offset_i,
  input  wire logic [CNT_W-1:0]  step_i,
  input  wire brb_cfg_t          cfg_i,
  output brb_mem_req_t           mem_req_o,
  output brb_res_t               res_o,
  output logic [CNT_W-1:0]       cap_o
);

  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  cap_q, cap_d;

  brb_action_e       act;
  logic [CNT_W-1:0]  space;
  logic [CNT_W-1:0]  ofs;
  logic              ok;
  logic              rd, wr;
  logic              addr_at_base;
  logic              use_wp;
  logic              upd_rp, upd_wp;
  logic [CNT_W-1:0]  amt;
  logic [CNT_W-1:0]  fill_new;
  logic [ADDR_W-1:0] base;
  logic [CNT_W:0]    sum_raw;
  logic [CNT_W:0]    sum_red;
  logic [ADDR_W-1:0] ring;
  logic [CNT_W-1:0]  cap_lim;

  assign act   = brb_action_e'(action_i);
  assign space = cap_q - fill_q;
  assign ofs   = CNT_W'(offset_i);

  always_comb begin
    ok           = 1'b0;
    rd           = 1'b0;
    wr           = 1'b0;
    addr_at_base = 1'b0;
    use_wp       = 1'b0;
    upd_rp       = 1'b0;
    upd_wp       = 1'b0;
    amt          = CNT_W'(1);
    fill_new     = fill_q;
    unique case (act)
      ACT_PUSH: begin
        ok           = (space != '0);
        wr           = 1'b1;
        addr_at_base = 1'b1;
        use_wp       = 1'b1;
        upd_wp       = 1'b1;
        fill_new     = fill_q + CNT_W'(1);
      end
      ACT_POP: begin
        ok           = (fill_q != '0);
        rd           = 1'b1;
        addr_at_base = 1'b1;
        upd_rp       = 1'b1;
        fill_new     = fill_q - CNT_W'(1);
      end
      ACT_PEEK: begin
        ok  = (ofs < fill_q);
        rd  = 1'b1;
        amt = ofs;
      end
      ACT_STAGE: begin
        ok     = (ofs < space);
        wr     = 1'b1;
        use_wp = 1'b1;
        amt    = ofs;
      end
      ACT_OVERWRITE: begin
        ok  = (ofs < fill_q);
        wr  = 1'b1;
        amt = ofs;
      end
      ACT_ADV_RD: begin
        ok       = (step_i <= fill_q);
        upd_rp   = 1'b1;
        amt      = step_i;
        fill_new = fill_q - step_i;
      end
      ACT_REW_RD: begin
        ok       = (step_i <= space);
        upd_rp   = 1'b1;
        amt      = cap_q - step_i;
        fill_new = fill_q + step_i;
      end
      ACT_COMMIT_WR: begin
        ok       = (step_i <= space);
        use_wp   = 1'b1;
        upd_wp   = 1'b1;
        amt      = step_i;
        fill_new = fill_q + step_i;
      end
      ACT_RETRACT_WR: begin
        ok       = (step_i <= fill_q);
        use_wp   = 1'b1;
        upd_wp   = 1'b1;
        amt      = cap_q - step_i;
        fill_new = fill_q - step_i;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Shared modular adder: base < capacity and amount <= capacity, so one
  // conditional subtract brings the sum back into range.
  assign base    = use_wp ? wp_q : rp_q;
  assign sum_raw = (CNT_W+1)'(base) + (CNT_W+1)'(amt);
  assign sum_red = (sum_raw >= (CNT_W+1)'(cap_q)) ? sum_raw - (CNT_W+1)'(cap_q) : sum_raw;
  assign ring    = sum_red[ADDR_W-1:0];

  always_comb begin
    mem_req_o.en    = accept_i & ok & (rd | wr);
    mem_req_o.we    = wr;
    mem_req_o.addr  = addr_at_base ? base : ring;
    mem_req_o.wdata = data_byte_i;
  end

  always_comb begin
    if (cfg_i.value == '0) begin
      cap_lim = CNT_W'(1);
    end else if (cfg_i.value > CAP_MAX) begin
      cap_lim = CAP_MAX;
    end else begin
      cap_lim = cfg_i.value;
    end
  end

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    fill_d = fill_q;
    cap_d  = cap_q;
    priority if (cfg_i.we) begin
      // The capacity changes only while nothing is held.
      if (fill_q == '0) begin
        cap_d = cap_lim;
        rp_d  = '0;
        wp_d  = '0;
      end
    end else if (accept_i && ok) begin
      fill_d = fill_new;
      if (upd_rp) begin
        rp_d = ring;
      end
      if (upd_wp) begin
        wp_d = ring;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      fill_q <= '0;
      cap_q  <= CAP_MAX;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      fill_q <= fill_d;
      cap_q  <= cap_d;
    end
  end

  always_comb begin
    res_o.accepted = ok;
    res_o.rd_en    = ok & rd;
    res_o.readable = ok ? fill_new : fill_q;
    res_o.writable = cap_q - (ok ? fill_new : fill_q);
  end

  assign cap_o = cap_q;

  `BRB_ASSERT(a_fill_in_range, clk_i, rst_ni, fill_q <= cap_q, "fill count above capacity")
  `BRB_ASSERT(a_ptrs_in_range, clk_i, rst_ni, (CNT_W'(rp_q) < cap_q) && (CNT_W'(wp_q) < cap_q), "pointer outside capacity")
  `BRB_ASSERT(a_refused_holds, clk_i, rst_ni, (accept_i && !ok && !cfg_i.we) |=> ($stable(fill_q) && $stable(rp_q) && $stable(wp_q)), "refused action changed state")

endmodule

`default_nettype wire
